// ===== rtl/sgdmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdmf_pkg
// Shared constants, payload types, sequencer codes and saturation helpers
// for the SGD matrix-factorisation update core.
// ----------------------------------------------------------------------------
package sgdmf_pkg;

    localparam int ROWS = 1024;
    localparam int COLS = 1024;
    localparam int RANK = 64;

    localparam int OP_W   = 3;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int RANK_W = 6;
    localparam int DATA_W = 32;
    localparam int FRAC   = 16;
    localparam int STEP_W = 24;
    localparam int LOSS_W = 48;

    // both factor stores are addressed {vector, element}; ROW_W equals COL_W
    localparam int MEM_AW    = ROW_W + RANK_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // dot-product accumulator: RANK terms of at most 48 signed bits
    localparam int ACC_W  = LOSS_W + RANK_W + 1;
    localparam int ERR_W  = ACC_W + 1;
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(838861);
    localparam logic [LOSS_W-1:0] LOSS_MAX   = '1;

    localparam logic [ROW_W:0]  ROW_LIM   = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]  COL_LIM   = (COL_W + 1)'(COLS);
    localparam logic [RANK_W:0] RANK_CNT  = (RANK_W + 1)'(RANK);
    localparam logic [RANK_W:0] RANK_LAST = (RANK_W + 1)'(RANK - 1);

    localparam logic [OP_W-1:0] OP_TRAIN = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_L  = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_R  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_L  = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_R  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         col_index;
        logic [RANK_W-1:0]        rank_index;
        logic signed [DATA_W-1:0] sample_value;
    } sgdmf_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic [DATA_W-1:0]        squared_error;
        logic [LOSS_W-1:0]        loss_sum;
        logic signed [DATA_W-1:0] read_value;
    } sgdmf_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_DATA,
        ST_CLEAR,
        ST_DOT,
        ST_DOT_DRAIN,
        ST_ERR,
        ST_ABS,
        ST_SQ_MUL,
        ST_SQ,
        ST_C,
        ST_UPD_RD,
        ST_UPD_A,
        ST_UPD_B,
        ST_UPD_LAST,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RT_NONE,
        RT_TRAIN,
        RT_WRITE,
        RT_READ,
        RT_CLEAR
    } route_t;

    typedef enum logic [2:0] {
        MUL_DOT,
        MUL_SQ,
        MUL_C,
        MUL_CR,
        MUL_CL
    } mul_sel_t;

    typedef struct packed {
        logic in_valid;
        route_t route;
        logic out_free;
    } sgdmf_status_t;

    typedef struct packed {
        logic              in_ready;
        logic              accept;
        logic              rd_en;
        logic [RANK_W-1:0] rd_idx;
        logic              wr_l;
        logic              wr_r;
        logic [RANK_W-1:0] wr_idx;
        logic              entry_wr;
        logic              entry_rd;
        logic              rd_capture;
        logic              acc_en;
        mul_sel_t          mul_sel;
        logic              err_en;
        logic              abs_en;
        logic              sq_en;
        logic              c_en;
        logic              loss_clr;
        logic              hold_en;
        logic              done_load;
    } sgdmf_ctrl_t;

    function automatic logic signed [PROD_W-1:0] sext_prod(
        input logic signed [DATA_W-1:0] v
    );
        return {{(PROD_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
        lo = {{(PROD_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
        if (v > hi)
            return {1'b0, {(DATA_W - 1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(DATA_W - 1){1'b0}}};
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/sgdmf_factor_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdmf_factor_mem
// One factor store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sgdmf_factor_mem
    import sgdmf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [MEM_AW-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [MEM_AW-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sgdmf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdmf_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module sgdmf_mul
    import sgdmf_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== rtl/sgdmf_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdmf_seq
// Sequencer: walks the dot-product pass, error/coefficient steps and the
// update pass (UPD_A, UPD_B per element) and steers the shared multiplier.
// ----------------------------------------------------------------------------
module sgdmf_seq
    import sgdmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sgdmf_status_t status,
    output sgdmf_ctrl_t   ctrl
);

    state_t            state_reg, state_next;
    logic [RANK_W:0]   cnt_reg, cnt_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [RANK_W-1:0] data_idx_reg, data_idx_next;
    logic [RANK_W-1:0] hold_idx_reg, hold_idx_next;
    logic              first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            data_idx_reg <= '0;
            hold_idx_reg <= '0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            data_idx_reg <= data_idx_next;
            hold_idx_reg <= hold_idx_next;
            first_reg    <= first_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        data_idx_next = data_idx_reg;
        hold_idx_next = hold_idx_reg;
        first_next    = first_reg;
        // read data valid, then product valid
        v1_next       = (state_reg == ST_DOT);
        v2_next       = v1_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    cnt_next = '0;
                    unique case (status.route)
                        RT_TRAIN: state_next = ST_DOT;
                        RT_WRITE: state_next = ST_WRITE;
                        RT_READ:  state_next = ST_READ;
                        RT_CLEAR: state_next = ST_CLEAR;
                        RT_NONE:  state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:     state_next = ST_DONE;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_CLEAR:     state_next = ST_DONE;
            ST_DOT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RANK_LAST)
                    state_next = ST_DOT_DRAIN;
            end
            ST_DOT_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_ERR;
            end
            ST_ERR:    state_next = ST_ABS;
            ST_ABS:    state_next = ST_SQ_MUL;
            ST_SQ_MUL: state_next = ST_SQ;
            ST_SQ:     state_next = ST_C;
            ST_C:
            begin
                cnt_next   = '0;
                state_next = ST_UPD_RD;
            end
            ST_UPD_RD:
            begin
                data_idx_next = cnt_reg[RANK_W-1:0];
                cnt_next      = cnt_reg + 1'b1;
                first_next    = 1'b1;
                state_next    = ST_UPD_A;
            end
            ST_UPD_A:
            begin
                hold_idx_next = data_idx_reg;
                first_next    = 1'b0;
                if (cnt_reg != RANK_CNT)
                begin
                    data_idx_next = cnt_reg[RANK_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                state_next = ST_UPD_B;
            end
            ST_UPD_B:
            begin
                if (hold_idx_reg == RANK_LAST[RANK_W-1:0])
                    state_next = ST_UPD_LAST;
                else
                    state_next = ST_UPD_A;
            end
            ST_UPD_LAST: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MUL_DOT;
        ctrl.rd_idx  = cnt_reg[RANK_W-1:0];
        ctrl.wr_idx  = hold_idx_reg;
        ctrl.acc_en  = v2_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.accept   = status.in_valid;
            end
            ST_WRITE:     ctrl.entry_wr   = 1'b1;
            ST_READ:      ctrl.entry_rd   = 1'b1;
            ST_READ_DATA: ctrl.rd_capture = 1'b1;
            ST_CLEAR:     ctrl.loss_clr   = 1'b1;
            ST_DOT:       ctrl.rd_en      = 1'b1;
            ST_DOT_DRAIN: ctrl.mul_sel    = MUL_DOT;
            ST_ERR:       ctrl.err_en     = 1'b1;
            ST_ABS:       ctrl.abs_en     = 1'b1;
            ST_SQ_MUL:    ctrl.mul_sel    = MUL_SQ;
            ST_SQ:
            begin
                ctrl.sq_en   = 1'b1;
                ctrl.mul_sel = MUL_C;
            end
            ST_C:         ctrl.c_en  = 1'b1;
            ST_UPD_RD:    ctrl.rd_en = 1'b1;
            ST_UPD_A:
            begin
                ctrl.mul_sel = MUL_CR;
                ctrl.hold_en = 1'b1;
                ctrl.wr_r    = !first_reg;
                ctrl.rd_en   = (cnt_reg != RANK_CNT);
            end
            ST_UPD_B:
            begin
                ctrl.mul_sel = MUL_CL;
                ctrl.wr_l    = 1'b1;
            end
            ST_UPD_LAST:  ctrl.wr_r      = 1'b1;
            ST_DONE:      ctrl.done_load = status.out_free;
            default:      ctrl.mul_sel   = MUL_DOT;
        endcase
    end

    // dot pass must be fully drained before the error is formed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR) |-> (!v1_reg && !v2_reg))
        else $error("error step entered with dot products in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.in_ready |-> (!v1_reg && !v2_reg))
        else $error("idle with dot pipeline busy");

    // right write-back trails the element just fetched by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_A && !first_reg)
            |-> (RANK_W'(hold_idx_reg + 1'b1) == data_idx_reg))
        else $error("update write-back out of step with fetch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_LAST) |-> (hold_idx_reg == RANK_LAST[RANK_W-1:0]))
        else $error("update pass ended before the last element");

endmodule

// ===== rtl/sgd_matrix_factor_update_core.sv =====
`timescale 1ns / 1ps
// Train word: paced from acceptance to result valid by the one shared
// multiplier: one product per element in the dot pass, two per element in
// the update pass. Entry write, entry read and clear pass through their own
// states to DONE, other words straight to DONE; words are taken only in IDLE.
// Reset (rst_n, async, active low): loss sum 0, step size 838861; factor
// stores hold nothing defined until written by software.
// ----------------------------------------------------------------------------
// sgd_matrix_factor_update_core
// SGD matrix-factorisation update engine: factor stores, shared multiplier,
// sequencer and fixed-point datapath (Q16.16 data, Q0.24 step).
// ----------------------------------------------------------------------------
module sgd_matrix_factor_update_core
    import sgdmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sgdmf_in_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sgdmf_out_t        out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data
);

    sgdmf_ctrl_t   ctrl;
    sgdmf_status_t status;
    route_t        route;

    sgdmf_in_t                item_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [LOSS_W-1:0]        loss_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic [DATA_W-1:0]        m_reg;
    logic                     big_reg;
    logic signed [DATA_W-1:0] es_reg;
    logic signed [DATA_W-1:0] pred_reg;
    logic [DATA_W-1:0]        sq_reg;
    logic signed [DATA_W-1:0] c_reg;
    logic signed [DATA_W-1:0] l_old_reg;
    logic signed [DATA_W-1:0] r_old_reg;
    logic signed [DATA_W-1:0] rd_reg;
    logic                     out_valid_reg;
    sgdmf_out_t               out_data_reg;

    logic [DATA_W-1:0]        l_q;
    logic [DATA_W-1:0]        r_q;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_sh16;

    logic [MEM_AW-1:0]        l_raddr, l_waddr, r_raddr, r_waddr;
    logic [DATA_W-1:0]        l_wdata, r_wdata;
    logic                     l_we, r_we, mem_re;
    logic [RANK_W-1:0]        ridx, widx;

    logic                     row_ok, col_ok, k_ok;
    logic signed [ERR_W-1:0]  e_calc;
    logic [ERR_W-1:0]         mag;
    logic [DATA_W-1:0]        sq_calc;
    logic [LOSS_W:0]          loss_sum;
    logic signed [DATA_W-1:0] new_l, new_r;

    // ---------------- word decode ----------------
    always_comb
    begin
        row_ok = ({1'b0, in_data.row_index} < ROW_LIM);
        col_ok = ({1'b0, in_data.col_index} < COL_LIM);
        k_ok   = ({1'b0, in_data.rank_index} < RANK_CNT);
        route  = RT_NONE;
        priority if (in_data.operation == OP_TRAIN)
        begin
            if (row_ok && col_ok)
                route = RT_TRAIN;
        end
        else if (in_data.operation == OP_WR_L)
        begin
            if (row_ok && k_ok)
                route = RT_WRITE;
        end
        else if (in_data.operation == OP_WR_R)
        begin
            if (col_ok && k_ok)
                route = RT_WRITE;
        end
        else if (in_data.operation == OP_RD_L)
        begin
            if (row_ok && k_ok)
                route = RT_READ;
        end
        else if (in_data.operation == OP_RD_R)
        begin
            if (col_ok && k_ok)
                route = RT_READ;
        end
        else if (in_data.operation == OP_CLEAR)
        begin
            route = RT_CLEAR;
        end
        else
        begin
            route = RT_NONE;
        end
    end

    assign status.in_valid = in_valid;
    assign status.route    = route;
    assign status.out_free = !out_valid_reg || out_ready;

    sgdmf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign in_ready = ctrl.in_ready;

    // ---------------- factor stores ----------------
    assign ridx    = ctrl.entry_rd ? item_reg.rank_index : ctrl.rd_idx;
    assign widx    = ctrl.entry_wr ? item_reg.rank_index : ctrl.wr_idx;
    assign l_raddr = {item_reg.row_index, ridx};
    assign r_raddr = {item_reg.col_index, ridx};
    assign l_waddr = {item_reg.row_index, widx};
    assign r_waddr = {item_reg.col_index, widx};
    assign mem_re  = ctrl.rd_en || ctrl.entry_rd;
    assign l_we    = ctrl.wr_l || (ctrl.entry_wr && item_reg.operation == OP_WR_L);
    assign r_we    = ctrl.wr_r || (ctrl.entry_wr && item_reg.operation == OP_WR_R);
    assign l_wdata = ctrl.entry_wr ? item_reg.sample_value : new_l;
    assign r_wdata = ctrl.entry_wr ? item_reg.sample_value : new_r;

    sgdmf_factor_mem u_left (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (mem_re),
        .raddr (l_raddr),
        .rdata (l_q)
    );

    sgdmf_factor_mem u_right (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (mem_re),
        .raddr (r_raddr),
        .rdata (r_q)
    );

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_DOT:
            begin
                mul_a = {l_q[DATA_W-1], l_q};
                mul_b = {r_q[DATA_W-1], r_q};
            end
            MUL_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            MUL_C:
            begin
                mul_a = {es_reg[DATA_W-1], es_reg};
                mul_b = {{(MUL_W - STEP_W){1'b0}}, step_reg};
            end
            MUL_CR:
            begin
                mul_a = {c_reg[DATA_W-1], c_reg};
                mul_b = {r_q[DATA_W-1], r_q};
            end
            MUL_CL:
            begin
                mul_a = {c_reg[DATA_W-1], c_reg};
                mul_b = {l_old_reg[DATA_W-1], l_old_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sgdmf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // ---------------- arithmetic ----------------
    always_comb
    begin
        prod_sh16 = mul_p >>> FRAC;
        e_calc    = {{(ERR_W - DATA_W){item_reg.sample_value[DATA_W-1]}},
                     item_reg.sample_value}
                  - {acc_reg[ACC_W-1], acc_reg};
        mag       = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : e_reg;
        // square of a 32-bit magnitude, Q32.32 -> Q16.16
        if (big_reg || (|mul_p[2*DATA_W-1:DATA_W+FRAC]))
            sq_calc = '1;
        else
            sq_calc = mul_p[DATA_W+FRAC-1:FRAC];
        loss_sum  = {1'b0, loss_reg} + (LOSS_W + 1)'(sq_reg);
        new_l     = sat32(sext_prod(l_old_reg) + prod_sh16);
        new_r     = sat32(sext_prod(r_old_reg) + prod_sh16);
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            item_reg <= in_data;
            acc_reg  <= '0;
            pred_reg <= '0;
            sq_reg   <= '0;
            rd_reg   <= '0;
        end
        if (ctrl.acc_en)
            acc_reg <= acc_reg + $signed(prod_sh16[ACC_W-1:0]);
        if (ctrl.err_en)
            e_reg <= e_calc;
        if (ctrl.abs_en)
        begin
            m_reg    <= mag[DATA_W-1:0];
            big_reg  <= |mag[ERR_W-1:DATA_W];
            es_reg   <= sat32({{(PROD_W - ERR_W){e_reg[ERR_W-1]}}, e_reg});
            pred_reg <= sat32({{(PROD_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg});
        end
        if (ctrl.sq_en)
            sq_reg <= sq_calc;
        // c = floor(2 * e * step / 2^24)
        if (ctrl.c_en)
            c_reg <= sat32(mul_p >>> (STEP_W - 1));
        if (ctrl.hold_en)
        begin
            l_old_reg <= l_q;
            r_old_reg <= r_q;
        end
        if (ctrl.rd_capture)
            rd_reg <= (item_reg.operation == OP_RD_L) ? l_q : r_q;
        if (ctrl.done_load)
        begin
            out_data_reg.prediction    <= pred_reg;
            out_data_reg.squared_error <= sq_reg;
            out_data_reg.loss_sum      <= loss_reg;
            out_data_reg.read_value    <= rd_reg;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RESET;
            loss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                step_reg <= cfg_data;
            if (ctrl.loss_clr)
                loss_reg <= '0;
            else if (ctrl.c_en)
                loss_reg <= loss_sum[LOSS_W] ? LOSS_MAX : loss_sum[LOSS_W-1:0];
            if (ctrl.done_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== dv/sgd_matrix_factor_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_matrix_factor_update_checker
// Watches the input, result and step-size channels of the SGD update core,
// keeps shadow factor stores, loss sum and step size, predicts every result
// word and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module sgd_matrix_factor_update_checker
    import sgdmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  sgdmf_in_t         in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  sgdmf_out_t        out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data,
    output int                fault_count,
    output int                results_due
);

    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam longint ERR_LIM = 64'sh0000_0001_0000_0000;
    localparam int     REPORT_MAX = 10;

    int                left_shadow [int];
    int                right_shadow [int];
    logic [LOSS_W-1:0] loss_model = '0;
    logic [STEP_W-1:0] rate = STEP_RESET;
    sgdmf_out_t        due_results [$];

    function automatic int clamp32(input longint v);
        if (v > S32_MAX)
            return int'(S32_MAX);
        if (v < S32_MIN)
            return int'(S32_MIN);
        return int'(v);
    endfunction

    function automatic int left_at(input int a);
        return left_shadow.exists(a) ? left_shadow[a] : 0;
    endfunction

    function automatic int right_at(input int a);
        return right_shadow.exists(a) ? right_shadow[a] : 0;
    endfunction

    // Applies one input word to the shadow state and returns its result word
    function automatic sgdmf_out_t apply_word(input sgdmf_in_t w);
        sgdmf_out_t        r;
        int                lbase;
        int                rbase;
        int                lo;
        int                ro;
        int                i;
        bit                row_ok;
        bit                col_ok;
        bit                k_ok;
        longint            dot;
        longint            err;
        longint            es;
        longint            coef;
        longint unsigned   mag;
        longint unsigned   sqw;
        longint unsigned   tot;
        r      = '0;
        row_ok = int'(w.row_index) < ROWS;
        col_ok = int'(w.col_index) < COLS;
        k_ok   = int'(w.rank_index) < RANK;
        lbase  = int'(w.row_index) * RANK;
        rbase  = int'(w.col_index) * RANK;
        if (w.operation == OP_TRAIN && row_ok && col_ok)
        begin
            dot = 0;
            for (i = 0; i < RANK; i++)
                dot += (longint'(left_at(lbase + i)) * longint'(right_at(rbase + i))) >>> FRAC;
            err = longint'(signed'(w.sample_value)) - dot;
            if (err >= ERR_LIM || err <= -ERR_LIM)
                sqw = 64'hFFFF_FFFF;
            else
            begin
                mag = (err < 0) ? -err : err;
                sqw = (mag * mag) >> FRAC;
                if (sqw > 64'hFFFF_FFFF)
                    sqw = 64'hFFFF_FFFF;
            end
            tot = loss_model + sqw;
            loss_model = (tot > LOSS_MAX) ? LOSS_MAX : tot[LOSS_W-1:0];
            es   = clamp32(err);
            coef = clamp32((2 * es * longint'(rate)) >>> STEP_W);
            // both vectors move from their old values
            for (i = 0; i < RANK; i++)
            begin
                lo = left_at(lbase + i);
                ro = right_at(rbase + i);
                left_shadow[lbase + i]  = clamp32(longint'(lo) + ((coef * longint'(ro)) >>> FRAC));
                right_shadow[rbase + i] = clamp32(longint'(ro) + ((coef * longint'(lo)) >>> FRAC));
            end
            r.prediction    = clamp32(dot);
            r.squared_error = sqw[DATA_W-1:0];
        end
        else if (w.operation == OP_WR_L && row_ok && k_ok)
            left_shadow[lbase + int'(w.rank_index)] = w.sample_value;
        else if (w.operation == OP_WR_R && col_ok && k_ok)
            right_shadow[rbase + int'(w.rank_index)] = w.sample_value;
        else if (w.operation == OP_RD_L && row_ok && k_ok)
            r.read_value = left_at(lbase + int'(w.rank_index));
        else if (w.operation == OP_RD_R && col_ok && k_ok)
            r.read_value = right_at(rbase + int'(w.rank_index));
        else if (w.operation == OP_CLEAR)
            loss_model = '0;
        r.loss_sum = loss_model;
        return r;
    endfunction

    function automatic void note_fault(input string what, input sgdmf_out_t want,
                                       input sgdmf_out_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("[%0t] %s: expected pred=%0d sq=%h loss=%h rd=%0d, got pred=%0d sq=%h loss=%h rd=%0d",
                     $time, what, want.prediction, want.squared_error, want.loss_sum,
                     want.read_value, got.prediction, got.squared_error, got.loss_sum,
                     got.read_value);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sgdmf_out_t want;
        if (!rst_n)
        begin
            loss_model = '0;
            rate       = STEP_RESET;
            due_results.delete();
            results_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rate = cfg_data;
            if (in_valid && in_ready)
                due_results.insert(due_results.size(), apply_word(in_data));
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    note_fault("result word with nothing due", '0, out_data);
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.prediction !== want.prediction
                        || out_data.squared_error !== want.squared_error
                        || out_data.loss_sum !== want.loss_sum
                        || out_data.read_value !== want.read_value)
                        note_fault("result word mismatch", want, out_data);
                end
            end
            results_due = due_results.size();
        end
    end

endmodule

// ===== dv/sgd_matrix_factor_update_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_matrix_factor_update_core_test
// Drives the SGD update core: entry writes and reads, training samples over
// fully loaded factor vectors, loss clears and unused codes, across several
// step sizes with random idling on both sides. Checking sits in the checker.
// ----------------------------------------------------------------------------
module sgd_matrix_factor_update_core_test;
    import sgdmf_pkg::*;

    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 5000;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef enum int {MAG_TINY, MAG_UNIT, MAG_FULL, MAG_EDGE} mag_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    sgdmf_in_t         in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    sgdmf_out_t        out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [STEP_W-1:0] cfg_data = '0;
    int                fault_count;
    int                results_due;
    bit                calm = 1'b0;
    int                quiet = 0;

    // written entries, so that reads and training only touch defined data
    bit                left_set [int];
    bit                right_set [int];
    int                left_keys [$];
    int                right_keys [$];
    int                left_rows [$];
    int                right_cols [$];

    sgd_matrix_factor_update_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sgd_matrix_factor_update_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fault_count (fault_count),
        .results_due (results_due)
    );

    // 4 ns period
    always #CLK_HALF_NS clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic [DATA_W-1:0] pick_value(input mag_t m);
        case (m)
            MAG_TINY: return DATA_W'(int'($urandom_range(32768)) - 16384);
            MAG_UNIT: return DATA_W'(int'($urandom_range(262144)) - 131072);
            MAG_FULL: return $urandom();
            default:  return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic sgdmf_in_t make_word(input logic [OP_W-1:0] op, input int row,
                                            input int col, input int k,
                                            input logic [DATA_W-1:0] val);
        sgdmf_in_t w;
        w.operation    = op;
        w.row_index    = ROW_W'(row);
        w.col_index    = COL_W'(col);
        w.rank_index   = RANK_W'(k);
        w.sample_value = val;
        return w;
    endfunction

    // Called just after a rising edge; returns at the edge that takes the word
    task automatic put_word(input sgdmf_in_t w);
        int key_l;
        int key_r;
        key_l = int'(w.row_index) * RANK + int'(w.rank_index);
        key_r = int'(w.col_index) * RANK + int'(w.rank_index);
        if (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (w.operation == OP_WR_L && !left_set.exists(key_l))
        begin
            left_set[key_l] = 1'b1;
            left_keys.insert(left_keys.size(), key_l);
        end
        if (w.operation == OP_WR_R && !right_set.exists(key_r))
        begin
            right_set[key_r] = 1'b1;
            right_keys.insert(right_keys.size(), key_r);
        end
    endtask

    task automatic put_step(input logic [STEP_W-1:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_vector(input bit right, input int idx, input mag_t m);
        int k;
        for (k = 0; k < RANK; k++)
            put_word(make_word(right ? OP_WR_R : OP_WR_L, idx, idx, k, pick_value(m)));
    endtask

    // Holds the input back until every result word has come home
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        int pick;
        int addr;
        int ra;
        int ca;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner entries, read back, unused codes, loss clear
        put_word(make_word(OP_WR_L, 0, 0, 0, 32'h7FFF_FFFF));
        put_word(make_word(OP_WR_L, 1023, 0, 63, 32'h8000_0000));
        put_word(make_word(OP_WR_R, 0, 0, 0, 32'h8000_0000));
        put_word(make_word(OP_WR_R, 0, 1023, 63, 32'h7FFF_FFFF));
        put_word(make_word(OP_RD_L, 0, 0, 0, '0));
        put_word(make_word(OP_RD_L, 1023, 1023, 63, '1));
        put_word(make_word(OP_RD_R, 0, 0, 0, '0));
        put_word(make_word(OP_RD_R, 1023, 1023, 63, '1));
        put_word(make_word(OP_SPARE_A, $urandom(), $urandom(), $urandom(), $urandom()));
        put_word(make_word(OP_SPARE_B, $urandom(), $urandom(), $urandom(), $urandom()));
        put_word(make_word(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom()));

        ra = 1 + $urandom_range(1021);
        ca = 1 + $urandom_range(1021);
        left_rows  = '{0, 1023, ra};
        right_cols = '{0, 1023, ca};
        load_vector(1'b0, 0, MAG_UNIT);
        load_vector(1'b0, 1023, MAG_EDGE);
        load_vector(1'b0, ra, MAG_TINY);
        load_vector(1'b1, 0, MAG_UNIT);
        load_vector(1'b1, 1023, MAG_EDGE);
        load_vector(1'b1, ca, MAG_TINY);

        // zero sample, extreme samples, saturated dot product
        put_word(make_word(OP_TRAIN, 0, 0, 0, '0));
        put_word(make_word(OP_TRAIN, 0, 0, 0, 32'h7FFF_FFFF));
        put_word(make_word(OP_TRAIN, 0, 0, 0, 32'h8000_0000));
        put_word(make_word(OP_TRAIN, 1023, 1023, 0, '0));
        put_word(make_word(OP_TRAIN, ra, 1023, 0, '0));
        put_word(make_word(OP_CLEAR, 0, 0, 0, '0));
        put_word(make_word(OP_TRAIN, ra, ca, 0, 32'h0001_0000));
        put_word(make_word(OP_RD_L, 0, 0, 5, '0));
        put_word(make_word(OP_RD_R, 0, 1023, 0, '0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_results();
                case (ph)
                    1: put_step('0);
                    2: put_step('1);
                    3: put_step(STEP_W'(1));
                    4: put_step(STEP_W'($urandom()));
                    default: put_step(STEP_W'($urandom_range(1 << 20)));
                endcase
                calm <= (ph == 3);
                // fresh contents for one vector, since big steps drive them to the rails
                if ($urandom_range(1))
                    load_vector(1'b0, left_rows[$urandom_range(left_rows.size() - 1)],
                                mag_t'($urandom_range(3)));
                else
                    load_vector(1'b1, right_cols[$urandom_range(right_cols.size() - 1)],
                                mag_t'($urandom_range(3)));
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    if ($urandom_range(1))
                        put_word(make_word(OP_WR_L,
                                           left_rows[$urandom_range(left_rows.size() - 1)],
                                           $urandom(), $urandom(),
                                           pick_value(mag_t'($urandom_range(3)))));
                    else
                        put_word(make_word(OP_WR_R, $urandom(),
                                           right_cols[$urandom_range(right_cols.size() - 1)],
                                           $urandom(), pick_value(mag_t'($urandom_range(3)))));
                end
                else if (pick < 30)
                    put_word(make_word($urandom_range(1) ? OP_WR_L : OP_WR_R, $urandom(),
                                       $urandom(), $urandom(), $urandom()));
                else if (pick < 45)
                begin
                    if ($urandom_range(1))
                    begin
                        addr = left_keys[$urandom_range(left_keys.size() - 1)];
                        put_word(make_word(OP_RD_L, addr / RANK, $urandom(), addr % RANK,
                                           $urandom()));
                    end
                    else
                    begin
                        addr = right_keys[$urandom_range(right_keys.size() - 1)];
                        put_word(make_word(OP_RD_R, $urandom(), addr / RANK, addr % RANK,
                                           $urandom()));
                    end
                end
                else if (pick < 50)
                    put_word(make_word(OP_CLEAR, $urandom(), $urandom(), $urandom(),
                                       $urandom()));
                else if (pick < 55)
                    put_word(make_word($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, $urandom(),
                                       $urandom(), $urandom(), $urandom()));
                else
                    put_word(make_word(OP_TRAIN,
                                       left_rows[$urandom_range(left_rows.size() - 1)],
                                       right_cols[$urandom_range(right_cols.size() - 1)],
                                       $urandom(), pick_value(mag_t'($urandom_range(3)))));
            end
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sgd_matrix_factor_update_core.f =====
rtl/sgdmf_pkg.sv
rtl/sgdmf_factor_mem.sv
rtl/sgdmf_mul.sv
rtl/sgdmf_seq.sv
rtl/sgd_matrix_factor_update_core.sv
dv/sgd_matrix_factor_update_checker.sv
dv/sgd_matrix_factor_update_core_test.sv
